### hw/rtl/sapq_pkg.sv
// shared types and constants of the sorted array priority queue
package sapq_pkg;

    localparam int CAPACITY = 8;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 16;
    localparam int PRI_W    = 8;
    localparam int HELD_W   = 4;

    typedef enum logic {
        FUNC_INSERT = 1'b0,
        FUNC_DELETE = 1'b1
    } t_func;

    typedef enum logic [1:0] {
        STATUS_INSERTED = 2'd0,
        STATUS_FULL     = 2'd1,
        STATUS_REMOVED  = 2'd2,
        STATUS_EMPTY    = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REFUSE = 2'd1,
        OP_DELETE = 2'd2,
        OP_EMPTY  = 2'd3
    } t_dp_op;

    typedef struct packed {
        logic   load;
        logic   exec;
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        t_func func;
        logic  full;
        logic  empty;
    } t_dp_stat;

endpackage

### hw/rtl/sapq_ifs.sv
// item channel interfaces of the priority queue
interface sapq_in_if;
    logic                        valid;
    logic                        ready;
    logic                        func;
    logic [sapq_pkg::DATA_W-1:0] item_data;
    logic [sapq_pkg::PRI_W-1:0]  item_priority;

    modport source (output valid, output func, output item_data, output item_priority,
                    input ready);
    modport sink (input valid, input func, input item_data, input item_priority,
                  output ready);
endinterface

interface sapq_out_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  status;
    logic [sapq_pkg::DATA_W-1:0] out_data;
    logic [sapq_pkg::PRI_W-1:0]  out_priority;
    logic [sapq_pkg::HELD_W-1:0] held_count;

    modport source (output valid, output status, output out_data, output out_priority,
                    output held_count, input ready);
    modport sink (input valid, input status, input out_data, input out_priority,
                  input held_count, output ready);
endinterface

### hw/rtl/sapq_ctrl.sv
// controller state machine of the priority queue
module sapq_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output sapq_pkg::t_dp_cmd  o_cmd,
    input  sapq_pkg::t_dp_stat i_stat
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        o_in_ready   = (r_state == S_IDLE);
        o_cmd.load   = i_in_valid && o_in_ready;
        o_cmd.exec   = (r_state == S_EXEC) && (!r_out_valid || i_out_ready);
        if (i_stat.func == sapq_pkg::FUNC_INSERT) begin
            o_cmd.op = i_stat.full ? sapq_pkg::OP_REFUSE : sapq_pkg::OP_INSERT;
        end else begin
            o_cmd.op = i_stat.empty ? sapq_pkg::OP_EMPTY : sapq_pkg::OP_DELETE;
        end
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (o_cmd.load) n_state = S_EXEC;
            end
            S_EXEC: begin
                if (o_cmd.exec) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
        n_out_valid = r_out_valid;
        if (o_cmd.exec) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    a_load_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == S_EXEC))
        else $error("accepted item did not start execution");

    a_exec_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.exec |=> r_out_valid)
        else $error("execution produced no result");

    a_insert_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.exec && o_cmd.op == sapq_pkg::OP_INSERT) |-> !i_stat.full)
        else $error("insert into full queue");

    a_delete_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.exec && o_cmd.op == sapq_pkg::OP_DELETE) |-> !i_stat.empty)
        else $error("delete from empty queue");

endmodule

### hw/rtl/sapq_dp.sv
// datapath of the priority queue: sorted slot array with per-slot compare
module sapq_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sapq_pkg::t_dp_cmd             i_cmd,
    input  logic                          i_func,
    input  logic [sapq_pkg::DATA_W-1:0]   i_item_data,
    input  logic [sapq_pkg::PRI_W-1:0]    i_item_priority,
    output sapq_pkg::t_dp_stat            o_stat,
    output logic [1:0]                    o_status,
    output logic [sapq_pkg::DATA_W-1:0]   o_out_data,
    output logic [sapq_pkg::PRI_W-1:0]    o_out_priority,
    output logic [sapq_pkg::HELD_W-1:0]   o_held_count
);

    localparam int CAP = sapq_pkg::CAPACITY;

    sapq_pkg::t_func               r_func;
    logic [sapq_pkg::DATA_W-1:0]   r_data;
    logic [sapq_pkg::PRI_W-1:0]    r_pri;
    logic [sapq_pkg::CNT_W-1:0]    r_count, n_count;
    logic [sapq_pkg::DATA_W-1:0]   r_slot_data [CAP];
    logic [sapq_pkg::PRI_W-1:0]    r_slot_pri  [CAP];
    logic [sapq_pkg::DATA_W-1:0]   n_slot_data [CAP];
    logic [sapq_pkg::PRI_W-1:0]    n_slot_pri  [CAP];
    sapq_pkg::t_status             r_res_status, n_res_status;
    logic [sapq_pkg::DATA_W-1:0]   r_res_data, n_res_data;
    logic [sapq_pkg::PRI_W-1:0]    r_res_pri, n_res_pri;
    logic [sapq_pkg::HELD_W-1:0]   r_res_held;
    logic [CAP-1:0]                lt;
    logic [CAP-1:0]                shift;
    logic [CAP-1:0]                place;

    always_comb begin
        for (int i = 0; i < CAP; i++) begin
            lt[i] = (sapq_pkg::CNT_W'(i) < r_count) && (r_slot_pri[i] < r_pri);
        end
        shift = {lt[CAP-2:0], 1'b0};
        for (int i = 0; i < CAP; i++) begin
            place[i] = !shift[i] && (lt[i] || (sapq_pkg::CNT_W'(i) == r_count));
        end
    end

    always_comb begin
        for (int i = 0; i < CAP; i++) begin
            n_slot_data[i] = r_slot_data[i];
            n_slot_pri[i]  = r_slot_pri[i];
        end
        n_count      = r_count;
        n_res_status = sapq_pkg::STATUS_INSERTED;
        n_res_data   = '0;
        n_res_pri    = '0;
        case (i_cmd.op)
            sapq_pkg::OP_INSERT: begin
                for (int i = 1; i < CAP; i++) begin
                    if (shift[i]) begin
                        n_slot_data[i] = r_slot_data[i-1];
                        n_slot_pri[i]  = r_slot_pri[i-1];
                    end
                end
                for (int i = 0; i < CAP; i++) begin
                    if (place[i]) begin
                        n_slot_data[i] = r_data;
                        n_slot_pri[i]  = r_pri;
                    end
                end
                n_count = r_count + 1'b1;
            end
            sapq_pkg::OP_REFUSE: begin
                n_res_status = sapq_pkg::STATUS_FULL;
            end
            sapq_pkg::OP_DELETE: begin
                for (int i = 0; i < CAP - 1; i++) begin
                    n_slot_data[i] = r_slot_data[i+1];
                    n_slot_pri[i]  = r_slot_pri[i+1];
                end
                n_count      = r_count - 1'b1;
                n_res_status = sapq_pkg::STATUS_REMOVED;
                n_res_data   = r_slot_data[0];
                n_res_pri    = r_slot_pri[0];
            end
            default: begin
                n_res_status = sapq_pkg::STATUS_EMPTY;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= sapq_pkg::t_func'(i_func);
            r_data <= i_item_data;
            r_pri  <= i_item_priority;
        end
        if (i_cmd.exec) begin
            for (int i = 0; i < CAP; i++) begin
                r_slot_data[i] <= n_slot_data[i];
                r_slot_pri[i]  <= n_slot_pri[i];
            end
            r_res_status <= n_res_status;
            r_res_data   <= n_res_data;
            r_res_pri    <= n_res_pri;
            r_res_held   <= sapq_pkg::HELD_W'(n_count);
        end
    end

    always_comb begin
        o_stat.func    = r_func;
        o_stat.full    = (r_count == sapq_pkg::CNT_W'(CAP));
        o_stat.empty   = (r_count == '0);
        o_status       = r_res_status;
        o_out_data     = r_res_data;
        o_out_priority = r_res_pri;
        o_held_count   = r_res_held;
    end

endmodule

### hw/rtl/sorted_array_priority_queue_top.sv
// top level of the sorted array priority queue
// an accepted item is loaded, then executed when the result register is empty or being read
// a new item is accepted only in the idle state, after the previous item has executed
// insert and delete each finish in the execute state; insert uses a parallel compare in every slot
// synchronous active-low reset empties the queue and clears the result register valid
module sorted_array_priority_queue_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sapq_in_if.sink    i_in,
    sapq_out_if.source o_out
);

    sapq_pkg::t_dp_cmd  cmd;
    sapq_pkg::t_dp_stat stat;
    logic               in_ready;
    logic               out_valid;

    sapq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    sapq_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_func          (i_in.func),
        .i_item_data     (i_in.item_data),
        .i_item_priority (i_in.item_priority),
        .o_stat          (stat),
        .o_status        (o_out.status),
        .o_out_data      (o_out.out_data),
        .o_out_priority  (o_out.out_priority),
        .o_held_count    (o_out.held_count)
    );

    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;

endmodule
